// ===== hdl/poi_pkg.sv =====
package poi_pkg;

   localparam int CordicSteps = 30;
   localparam int StepW = 5;
   localparam logic [31:0] CordicGain = 32'd652032874;
   localparam logic [31:0] TurnPerRad = 32'd683565276;
   localparam logic signed [35:0] OneQ30 = 36'sd1073741824;

   typedef enum logic [1:0] {
      KIND_WHEEL = 2'd0,
      KIND_GYRO  = 2'd1,
      KIND_TICK  = 2'd2,
      KIND_RESET = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_ROT, ST_MUL, ST_MWAIT, ST_HALF, ST_HWAIT, ST_OUT
   } state_type;

   // order of the products on the shared multiplier
   typedef enum logic [3:0] {
      MS_VX_COS, MS_VY_SIN, MS_VX_SIN, MS_VY_COS,
      MS_X_HI, MS_X_LO, MS_Y_HI, MS_Y_LO,
      MS_RATE_DT, MS_HI_K, MS_LO_K
   } mul_step_type;

   typedef struct packed {
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
      logic signed [31:0] yaw_rate;
      logic [31:0]        elapsed;
      logic [1:0]         kind;
   } req_word_type;

   typedef struct packed {
      logic signed [47:0] pos_x;
      logic signed [47:0] pos_y;
      logic signed [31:0] quat_z;
      logic signed [31:0] quat_w;
   } rsp_word_type;

   // CORDIC angle table in turns
   function automatic logic [31:0] atan_turn(input logic [StepW-1:0] i);
      logic [31:0] r;
      begin
         case (i)
            5'd0: r = 32'h20000000; 5'd1: r = 32'h12E4051D; 5'd2: r = 32'h09FB385B;
            5'd3: r = 32'h051111D4; 5'd4: r = 32'h028B0D43; 5'd5: r = 32'h0145D7E1;
            5'd6: r = 32'h00A2F61E; 5'd7: r = 32'h00517C55; 5'd8: r = 32'h0028BE53;
            5'd9: r = 32'h00145F2E; 5'd10: r = 32'h000A2F98; 5'd11: r = 32'h000517CC;
            5'd12: r = 32'h00028BE6; 5'd13: r = 32'h000145F3; 5'd14: r = 32'h0000A2F9;
            5'd15: r = 32'h0000517C; 5'd16: r = 32'h000028BE; 5'd17: r = 32'h0000145F;
            5'd18: r = 32'h00000A2F; 5'd19: r = 32'h00000517; 5'd20: r = 32'h0000028B;
            5'd21: r = 32'h00000145; 5'd22: r = 32'h000000A2; 5'd23: r = 32'h00000051;
            5'd24: r = 32'h00000028; 5'd25: r = 32'h00000014; 5'd26: r = 32'h0000000A;
            5'd27: r = 32'h00000005; 5'd28: r = 32'h00000002; 5'd29: r = 32'h00000001;
            default: r = 32'h0;
         endcase
         return r;
      end
   endfunction

endpackage

// ===== hdl/poi_if.sv =====
interface poi_req_if;
   import poi_pkg::*;
   logic valid;
   logic ready;
   req_word_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface poi_rsp_if;
   import poi_pkg::*;
   logic valid;
   logic ready;
   rsp_word_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/poi_cordic.sv =====
// One CORDIC micro-rotation per cycle; angle in turns, quadrant folded.
module poi_cordic (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [31:0]         angle,
   output logic                done,
   output logic signed [31:0]  sin_out,
   output logic signed [31:0]  cos_out
);
   import poi_pkg::*;

   logic signed [35:0] x_ff, x_in, y_ff, y_in;
   logic signed [35:0] z_ff, z_in;
   logic [1:0] q_ff, q_in;
   logic [StepW-1:0] step_ff, step_in;
   logic busy_ff, busy_in, done_ff, done_in;
   logic [31:0] a;
   logic signed [35:0] xs, ys, xc, yc, tab;

   always_comb begin
      a = angle + 32'h20000000;
      xs = x_ff >>> step_ff;
      ys = y_ff >>> step_ff;
      tab = $signed({4'd0, atan_turn(step_ff)});
      x_in = x_ff; y_in = y_ff; z_in = z_ff; q_in = q_ff;
      step_in = step_ff; busy_in = busy_ff; done_in = 1'b0;
      if (start) begin
         x_in = $signed({4'd0, CordicGain});
         y_in = '0;
         z_in = $signed({6'd0, a[29:0]}) - 36'sh20000000;
         q_in = a[31:30];
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!z_ff[35]) begin
            x_in = x_ff - ys; y_in = y_ff + xs; z_in = z_ff - tab;
         end else begin
            x_in = x_ff + ys; y_in = y_ff - xs; z_in = z_ff + tab;
         end
         step_in = step_ff + 1'b1;
         if (step_ff == StepW'(CordicSteps - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in; y_ff <= y_in; z_ff <= z_in; q_ff <= q_in; step_ff <= step_in;
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in;
      end
   end

   // clamp and quadrant mapping
   always_comb begin
      xc = (x_ff > OneQ30) ? OneQ30 : (x_ff < -OneQ30) ? -OneQ30 : x_ff;
      yc = (y_ff > OneQ30) ? OneQ30 : (y_ff < -OneQ30) ? -OneQ30 : y_ff;
      unique case (q_ff)
         2'd0: begin sin_out = yc[31:0]; cos_out = xc[31:0]; end
         2'd1: begin sin_out = xc[31:0]; cos_out = -yc[31:0]; end
         2'd2: begin sin_out = -yc[31:0]; cos_out = -xc[31:0]; end
         default: begin sin_out = -xc[31:0]; cos_out = yc[31:0]; end
      endcase
   end
   assign done = done_ff;
endmodule

// ===== hdl/poi_mul.sv =====
// Shift-add multiplier: one two-bit digit of the multiplier per cycle.
module poi_mul (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic signed [35:0]  mcand,
   input  logic [31:0]         mplier,
   output logic                done,
   output logic signed [67:0]  product
);
   import poi_pkg::*;

   logic signed [67:0] acc_ff, acc_in;
   logic signed [67:0] md_ff, md_in;
   logic [31:0] mp_ff, mp_in;
   logic [4:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in, done_ff, done_in;
   logic signed [67:0] part;

   always_comb begin
      acc_in = acc_ff; md_in = md_ff; mp_in = mp_ff; cnt_in = cnt_ff;
      busy_in = busy_ff; done_in = 1'b0;
      part = '0;
      if (mp_ff[0]) part = md_ff;
      if (mp_ff[1]) part = part + (md_ff <<< 1);
      if (start) begin
         acc_in = '0;
         md_in = 68'(mcand);
         mp_in = mplier;
         cnt_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in = acc_ff + part;
         md_in = md_ff <<< 2;
         mp_in = mp_ff >> 2;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == 5'd15) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in; md_ff <= md_in; mp_ff <= mp_in; cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign product = acc_ff;
endmodule

// ===== hdl/planar_odometry_integrator_top.sv =====
// Planar dead-reckoning integrator.
// req: one word per sample, tick or pose reset (field kind selects which).
// rsp: one word (pos_x, pos_y, quat_z, quat_w) per integrating tick only.
// Samples, pose resets and ticks that only arm or are ignored are taken
// one per cycle while the block is idle.
// An integrating tick runs a 30-step CORDIC on the old heading, then eleven
// products on a shared two-bit-per-cycle multiplier, then a second CORDIC
// on half the new heading; the block takes no words while it does so, and
// takes the next word once it is back in idle after writing the result.
// The result sits in an output register; the block keeps taking words and
// working on the next tick while it waits, and holds a finished tick (still
// not taking words) until that register is free.
// reset clears the pose, the stored samples and the seen/armed flags.
module planar_odometry_integrator_top (
   input  logic clock,
   input  logic reset,
   poi_req_if.sink   req,
   poi_rsp_if.source rsp
);
   import poi_pkg::*;

   state_type st_ff, st_in;
   mul_step_type mi_ff, mi_in;
   logic signed [31:0] vx_ff, vx_in, vy_ff, vy_in, gr_ff, gr_in;
   logic [31:0] dt_ff, dt_in, hd_ff, hd_in;
   logic signed [47:0] px_ff, px_in, py_ff, py_in;
   logic wseen_ff, wseen_in, gseen_ff, gseen_in, armed_ff, armed_in;
   logic signed [63:0] rx_ff, rx_in, ry_ff, ry_in, hp_ff, hp_in;
   logic [48:0] dh_ff, dh_in;
   logic [47:0] dx_ff, dx_in, dy_ff, dy_in;
   logic [39:0] hk_ff, hk_in;
   logic rv_ff, rv_in;
   rsp_word_type rd_ff, rd_in;
   logic accept;
   logic c_start, c_done, m_start, m_done;
   logic [31:0] c_ang;
   logic signed [31:0] c_sin, c_cos;
   logic signed [35:0] m_cand;
   logic [31:0] m_plier;
   logic signed [67:0] m_prod, prod_fix;
   logic [40:0] mx, my;
   logic [49:0] dsum;
   logic [47:0] dcap;
   logic [39:0] hsum;

   poi_cordic u_cordic (.clock, .reset, .start(c_start), .angle(c_ang),
      .done(c_done), .sin_out(c_sin), .cos_out(c_cos));
   poi_mul u_mul (.clock, .reset, .start(m_start), .mcand(m_cand),
      .mplier(m_plier), .done(m_done), .product(m_prod));

   assign req.ready = (st_ff == ST_IDLE);
   assign accept = req.valid && req.ready;

   // saturating add of a capped displacement magnitude
   function automatic logic signed [47:0] sat_add(input logic signed [47:0] pos,
         input logic neg, input logic [47:0] d);
      logic signed [49:0] s;
      s = neg ? 50'(pos) - $signed({2'b00, d}) : 50'(pos) + $signed({2'b00, d});
      if (s > 50'sh7FFFFFFFFFFF) s = 50'sh7FFFFFFFFFFF;
      if (s < -(50'sh800000000000)) s = -(50'sh800000000000);
      return s[47:0];
   endfunction

   // rotated velocity floored to Q24, as magnitudes
   always_comb begin
      mx = rx_ff[63] ? 41'(-(rx_ff >>> 22)) : 41'(rx_ff >>> 22);
      my = ry_ff[63] ? 41'(-(ry_ff >>> 22)) : 41'(ry_ff >>> 22);
   end

   // multiplier operands; the CORDIC holds its result until its next start
   always_comb begin
      m_cand = '0; m_plier = '0;
      unique case (mi_ff)
         MS_VX_COS: begin m_cand = 36'(vx_ff); m_plier = c_cos; end
         MS_VY_SIN: begin m_cand = 36'(vy_ff); m_plier = c_sin; end
         MS_VX_SIN: begin m_cand = 36'(vx_ff); m_plier = c_sin; end
         MS_VY_COS: begin m_cand = 36'(vy_ff); m_plier = c_cos; end
         MS_X_HI: begin m_cand = $signed({19'd0, mx[40:24]}); m_plier = dt_ff; end
         MS_X_LO: begin m_cand = $signed({12'd0, mx[23:0]}); m_plier = dt_ff; end
         MS_Y_HI: begin m_cand = $signed({19'd0, my[40:24]}); m_plier = dt_ff; end
         MS_Y_LO: begin m_cand = $signed({12'd0, my[23:0]}); m_plier = dt_ff; end
         MS_RATE_DT: begin m_cand = 36'(gr_ff); m_plier = dt_ff; end
         MS_HI_K: begin m_cand = 36'($signed(hp_ff[63:32])); m_plier = TurnPerRad; end
         MS_LO_K: begin m_cand = $signed({4'd0, hp_ff[31:0]}); m_plier = TurnPerRad; end
         default: ;
      endcase
   end

   // sine and cosine are signed multipliers: undo the unsigned weight of bit 31
   always_comb begin
      prod_fix = m_prod;
      if (mi_ff < MS_X_HI && m_plier[31]) prod_fix = m_prod - (68'(m_cand) <<< 32);
   end

   // state machine
   always_comb begin
      st_in = st_ff; mi_in = mi_ff; rv_in = rv_ff; rd_in = rd_ff;
      vx_in = vx_ff; vy_in = vy_ff; gr_in = gr_ff; dt_in = dt_ff;
      px_in = px_ff; py_in = py_ff; hd_in = hd_ff;
      wseen_in = wseen_ff; gseen_in = gseen_ff; armed_in = armed_ff;
      rx_in = rx_ff; ry_in = ry_ff; hp_in = hp_ff;
      dh_in = dh_ff; dx_in = dx_ff; dy_in = dy_ff; hk_in = hk_ff;
      c_start = 1'b0; c_ang = hd_ff; m_start = 1'b0;
      // displacement: hi*dt + (lo*dt >> 24), capped at 2^47
      dsum = {1'b0, dh_ff} + {18'd0, m_prod[55:24]};
      dcap = (dsum > 50'h800000000000) ? 48'h800000000000 : dsum[47:0];
      // heading step: low 40 bits of rate*dt*K >> 32
      hsum = hk_ff + {8'd0, m_prod[63:32]};
      if (rv_ff && rsp.ready) rv_in = 1'b0;
      unique case (st_ff)
         ST_IDLE: if (accept) begin
            unique case (kind_type'(req.data.kind))
               KIND_WHEEL: begin
                  vx_in = req.data.vel_x; vy_in = req.data.vel_y; wseen_in = 1'b1;
               end
               KIND_GYRO: begin
                  gr_in = req.data.yaw_rate; gseen_in = 1'b1;
               end
               KIND_RESET: begin
                  px_in = '0; py_in = '0; hd_in = '0;
               end
               default: begin
                  dt_in = req.data.elapsed;
                  if (wseen_ff && gseen_ff) begin
                     armed_in = 1'b1;
                     if (armed_ff) begin
                        c_start = 1'b1;
                        st_in = ST_ROT;
                     end
                  end
               end
            endcase
         end
         ST_ROT: if (c_done) begin
            mi_in = MS_VX_COS; st_in = ST_MUL;
         end
         ST_MUL: begin
            m_start = 1'b1; st_in = ST_MWAIT;
         end
         ST_MWAIT: if (m_done) begin
            case (mi_ff)
               MS_VX_COS: rx_in = prod_fix[63:0];
               MS_VY_SIN: rx_in = rx_ff - prod_fix[63:0];
               MS_VX_SIN: ry_in = prod_fix[63:0];
               MS_VY_COS: ry_in = ry_ff + prod_fix[63:0];
               MS_X_HI: dh_in = m_prod[48:0];
               MS_X_LO: dx_in = dcap;
               MS_Y_HI: dh_in = m_prod[48:0];
               MS_Y_LO: dy_in = dcap;
               MS_RATE_DT: hp_in = m_prod[63:0];
               MS_HI_K: hk_in = m_prod[39:0];
               MS_LO_K: begin
                  hd_in = hd_ff + hsum[39:8];
                  px_in = sat_add(px_ff, rx_ff[63], dx_ff);
                  py_in = sat_add(py_ff, ry_ff[63], dy_ff);
               end
               default: ;
            endcase
            if (mi_ff == MS_LO_K) st_in = ST_HALF;
            else begin
               mi_in = mul_step_type'(mi_ff + 4'd1);
               st_in = ST_MUL;
            end
         end
         ST_HALF: begin
            c_start = 1'b1; c_ang = {1'b0, hd_ff[31:1]}; st_in = ST_HWAIT;
         end
         ST_HWAIT: if (c_done) st_in = ST_OUT;
         ST_OUT: if (!rv_ff || rsp.ready) begin
            rd_in.pos_x = px_ff; rd_in.pos_y = py_ff;
            rd_in.quat_z = c_sin; rd_in.quat_w = c_cos;
            rv_in = 1'b1; st_in = ST_IDLE;
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      dt_ff <= dt_in; rx_ff <= rx_in; ry_ff <= ry_in; hp_ff <= hp_in;
      dh_ff <= dh_in; dx_ff <= dx_in; dy_ff <= dy_in; hk_ff <= hk_in;
      rd_ff <= rd_in;
      if (reset) begin
         st_ff <= ST_IDLE; mi_ff <= MS_VX_COS; rv_ff <= 1'b0;
         vx_ff <= '0; vy_ff <= '0; gr_ff <= '0;
         px_ff <= '0; py_ff <= '0; hd_ff <= '0;
         wseen_ff <= 1'b0; gseen_ff <= 1'b0; armed_ff <= 1'b0;
      end else begin
         st_ff <= st_in; mi_ff <= mi_in; rv_ff <= rv_in;
         vx_ff <= vx_in; vy_ff <= vy_in; gr_ff <= gr_in;
         px_ff <= px_in; py_ff <= py_in; hd_ff <= hd_in;
         wseen_ff <= wseen_in; gseen_ff <= gseen_in; armed_ff <= armed_in;
      end
   end

   assign rsp.valid = rv_ff;
   assign rsp.data = rd_ff;

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (st_ff != ST_IDLE) |-> !req.ready) else $error("accept while busy");
   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rv_ff) |-> $past(st_ff) == ST_OUT) else $error("stray response");
   a_unarmed_quiet: assert property (@(posedge clock) disable iff (reset)
      !armed_ff |-> st_ff == ST_IDLE) else $error("tick before armed");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.data))
      else $error("response word dropped or changed");
endmodule

// ===== dv/poi_odometry_checker.sv =====
`timescale 1ns / 100ps

module poi_odometry_checker (
   input  logic clock,
   input  logic reset,
   poi_req_if   req,
   poi_rsp_if   rsp,
   output int   fail_count,
   output int   pose_pending
);
   import poi_pkg::*;

   localparam longint PosMax = 64'sd140737488355327;
   localparam longint PosMin = -64'sd140737488355328;
   localparam longint UnitQ30 = 64'sd1073741824;

   // own copy of the integrator state
   longint     vx_q, vy_q, yaw_q;
   longint     px_q, py_q;
   logic [31:0] hdg_q;
   logic        wheel_ok, gyro_ok, is_armed;

   rsp_word_type pose_fifo[$];

   function automatic longint unit_clamp(input longint v);
      if (v > UnitQ30) return UnitQ30;
      if (v < -UnitQ30) return -UnitQ30;
      return v;
   endfunction

   // CORDIC on an angle in turns, folded into the right quadrant
   task automatic turn_sincos(input logic [31:0] ang, output longint s, output longint c);
      logic [31:0] a;
      logic [1:0]  q;
      longint      x, y, z, xs, ys;
      a = ang + 32'h20000000;
      q = a[31:30];
      z = longint'({34'd0, a[29:0]}) - 64'sh20000000;
      x = longint'(CordicGain);
      y = 0;
      for (int i = 0; i < CordicSteps; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (z >= 0) begin
            x -= ys; y += xs; z -= longint'(atan_turn(i[StepW-1:0]));
         end else begin
            x += ys; y -= xs; z += longint'(atan_turn(i[StepW-1:0]));
         end
      end
      x = unit_clamp(x);
      y = unit_clamp(y);
      case (q)
         2'd0: begin s = y;  c = x;  end
         2'd1: begin s = x;  c = -y; end
         2'd2: begin s = -y; c = -x; end
         default: begin s = -x; c = y; end
      endcase
   endtask

   // one axis: capped displacement then saturating add
   function automatic longint axis_step(input longint pos, input longint rot,
                                        input longint unsigned dt);
      longint          m, sum;
      logic            neg;
      longint unsigned mag, d;
      m = rot >>> 22;
      neg = m < 0;
      mag = neg ? longint'(-m) : m;
      d = (mag >> 24) * dt + (((mag & 64'hFFFFFF) * dt) >> 24);
      if (d > (64'd1 << 47)) d = 64'd1 << 47;
      sum = neg ? pos - longint'(d) : pos + longint'(d);
      if (sum > PosMax) return PosMax;
      if (sum < PosMin) return PosMin;
      return sum;
   endfunction

   task automatic predict_pose(input req_word_type w);
      longint          s, c, p, ph, m;
      longint unsigned dt, pl, ah;
      logic [63:0]     mv;
      rsp_word_type    r;
      dt = {32'd0, w.elapsed};
      case (kind_type'(w.kind))
         KIND_WHEEL: begin
            vx_q = longint'(w.vel_x); vy_q = longint'(w.vel_y); wheel_ok = 1'b1;
         end
         KIND_GYRO: begin
            yaw_q = longint'(w.yaw_rate); gyro_ok = 1'b1;
         end
         KIND_RESET: begin
            px_q = 0; py_q = 0; hdg_q = '0;
         end
         default: begin
            if (wheel_ok && gyro_ok) begin
               if (!is_armed) is_armed = 1'b1;
               else begin
                  turn_sincos(hdg_q, s, c);
                  px_q = axis_step(px_q, vx_q * c - vy_q * s, dt);
                  py_q = axis_step(py_q, vx_q * s + vy_q * c, dt);
                  // heading advance in turns, wraps modulo one
                  p = yaw_q * longint'(dt);
                  ph = p >>> 32;
                  pl = p & 64'hFFFFFFFF;
                  ah = (pl * longint'(TurnPerRad)) >> 32;
                  m = ph * longint'(TurnPerRad) + longint'(ah);
                  mv = m;
                  hdg_q = hdg_q + mv[39:8];
                  turn_sincos({1'b0, hdg_q[31:1]}, s, c);
                  r.pos_x = px_q[47:0];
                  r.pos_y = py_q[47:0];
                  r.quat_z = s[31:0];
                  r.quat_w = c[31:0];
                  pose_fifo.push_back(r);
               end
            end
         end
      endcase
   endtask

   always @(posedge clock) begin
      rsp_word_type e;
      if (reset) begin
         vx_q = 0; vy_q = 0; yaw_q = 0; px_q = 0; py_q = 0; hdg_q = '0;
         wheel_ok = 1'b0; gyro_ok = 1'b0; is_armed = 1'b0;
         pose_fifo.delete();
         fail_count = 0;
      end else begin
         // result word first: it cannot depend on a word taken this edge
         if (rsp.valid && rsp.ready) begin
            if (pose_fifo.size() == 0) begin
               $error("unexpected pose word %p", rsp.data);
               fail_count++;
            end else begin
               e = pose_fifo.pop_front();
               if (rsp.data.pos_x !== e.pos_x) begin
                  $error("pos_x expected %0d got %0d", e.pos_x, rsp.data.pos_x);
                  fail_count++;
               end
               if (rsp.data.pos_y !== e.pos_y) begin
                  $error("pos_y expected %0d got %0d", e.pos_y, rsp.data.pos_y);
                  fail_count++;
               end
               if (rsp.data.quat_z !== e.quat_z) begin
                  $error("quat_z expected %0d got %0d", e.quat_z, rsp.data.quat_z);
                  fail_count++;
               end
               if (rsp.data.quat_w !== e.quat_w) begin
                  $error("quat_w expected %0d got %0d", e.quat_w, rsp.data.quat_w);
                  fail_count++;
               end
            end
         end
         if (req.valid && req.ready) predict_pose(req.data);
      end
      pose_pending = pose_fifo.size();
   end

endmodule

// ===== dv/tb_planar_odometry_integrator_top.sv =====
`timescale 1ns / 100ps

module tb_planar_odometry_integrator_top;
   import poi_pkg::*;

   typedef enum int {PH_FREE, PH_SEND_IDLE, PH_RECV_STALL, PH_BOTH, PH_HOLD} phase_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fail_count, pose_pending;
   int   tx_idle_pct = 0, rx_stall_pct = 0;
   int   hold_left = 0;
   logic hold_done = 1'b0;
   phase_type phase = PH_FREE;

   poi_req_if req ();
   poi_rsp_if rsp ();

   planar_odometry_integrator_top dut (.clock(clock), .reset(reset), .req(req), .rsp(rsp));
   poi_odometry_checker checker_i (.clock(clock), .reset(reset), .req(req), .rsp(rsp),
                                   .fail_count(fail_count), .pose_pending(pose_pending));

   always #2 clock = ~clock;

   // receiver: random stalls, one long hold-off in the pressure phase
   always @(posedge clock) begin
      if (reset) rsp.ready <= 1'b0;
      else if (phase == PH_HOLD && !hold_done && hold_left == 0) begin
         hold_left <= 3000;
         hold_done <= 1'b1;
         rsp.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp.ready <= 1'b0;
      end else rsp.ready <= ($urandom_range(99) >= rx_stall_pct);
   end

   // offer one word, hold it until taken
   task automatic offer_word(input kind_type k, input logic [31:0] a, input logic [31:0] b);
      req_word_type w;
      w.kind = k;
      w.vel_x = $urandom; w.vel_y = $urandom;
      w.yaw_rate = $urandom; w.elapsed = $urandom;
      case (k)
         KIND_WHEEL: begin w.vel_x = a; w.vel_y = b; end
         KIND_GYRO:  w.yaw_rate = a;
         KIND_TICK:  w.elapsed = a;
         default: ;
      endcase
      if ($urandom_range(99) < tx_idle_pct) begin
         req.valid <= 1'b0;
         repeat ($urandom_range(8, 1)) @(posedge clock);
      end
      req.valid <= 1'b1;
      req.data <= w;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
   endtask

   task automatic random_word();
      int r;
      logic [31:0] dt;
      r = $urandom_range(99);
      dt = ($urandom_range(9) == 0) ? $urandom : $urandom_range(32'h00FFFFFF);
      if (r < 25) offer_word(KIND_WHEEL, $urandom, $urandom);
      else if (r < 45) offer_word(KIND_GYRO, $urandom, 0);
      else if (r < 95) offer_word(KIND_TICK, dt, 0);
      else offer_word(KIND_RESET, 0, 0);
   endtask

   initial begin
      req.valid <= 1'b0;
      req.data <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: unseen ticks, arming, extremes, saturation, pose reset
      offer_word(KIND_TICK, 32'h01000000, 0);
      offer_word(KIND_WHEEL, 32'h00010000, 0);
      offer_word(KIND_TICK, 32'h01000000, 0);
      offer_word(KIND_GYRO, 32'h00010000, 0);
      offer_word(KIND_TICK, 32'h01000000, 0);
      offer_word(KIND_TICK, 32'h01000000, 0);
      offer_word(KIND_TICK, 32'h00000000, 0);
      offer_word(KIND_WHEEL, 32'h7FFFFFFF, 32'h80000000);
      offer_word(KIND_GYRO, 32'h7FFFFFFF, 0);
      offer_word(KIND_TICK, 32'hFFFFFFFF, 0);
      offer_word(KIND_TICK, 32'hFFFFFFFF, 0);
      offer_word(KIND_TICK, 32'hFFFFFFFF, 0);
      offer_word(KIND_WHEEL, 32'h80000000, 32'h7FFFFFFF);
      offer_word(KIND_GYRO, 32'h80000000, 0);
      offer_word(KIND_TICK, 32'hFFFFFFFF, 0);
      offer_word(KIND_TICK, 32'hFFFFFFFF, 0);
      offer_word(KIND_RESET, 0, 0);
      offer_word(KIND_TICK, 32'h00800000, 0);
      offer_word(KIND_WHEEL, 32'hFFFF0000, 32'h00008000);
      offer_word(KIND_GYRO, 32'hFFFFFFFF, 0);
      offer_word(KIND_TICK, 32'h00000001, 0);
      offer_word(KIND_TICK, 32'h00400000, 0);

      // random phases, the hold-off one among them
      for (int ph = 0; ph < 6; ph++) begin
         phase = phase_type'(ph % 5);
         case (phase)
            PH_FREE:       begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
            PH_SEND_IDLE:  begin tx_idle_pct = 75; rx_stall_pct = 0;  end
            PH_RECV_STALL: begin tx_idle_pct = 0;  rx_stall_pct = 75; end
            PH_BOTH:       begin tx_idle_pct = 19; rx_stall_pct = 19; end
            default:       begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
         endcase
         repeat (100) random_word();
      end
      req.valid <= 1'b0;

      while (pose_pending != 0) @(posedge clock);
      repeat (400) @(posedge clock);
      if (fail_count == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end

   initial begin
      #4ms;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
